// ===== rtl/hpnv_pkg.sv =====
// Shared types and constants for the host/port name validator.
// Holds character codes, parse modes, limits and the classified-byte record.
// No dependencies.
package hpnv_pkg;

	// parse modes
	localparam logic [1:0] MODE_HOST_PORT = 2'd0;
	localparam logic [1:0] MODE_DOMAIN    = 2'd1;
	localparam logic [1:0] MODE_DOMAIN_LC = 2'd2;

	// characters with a role of their own
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_DASH     = 8'h2D;

	// syntax limits
	localparam int MAX_LABEL        = 63;
	localparam int MAX_NAME         = 255;
	localparam int MAX_LITERAL      = 39;
	localparam int MAX_GROUP_DIGITS = 4;
	localparam int MAX_PORT_DIGITS  = 5;

	// queue depths
	localparam int HPNV_QUEUE_DEPTH  = 4;
	localparam int HPNV_RESULT_DEPTH = 2;

	// one byte after classification, as it travels from front to back
	typedef struct packed {
		logic [1:0] mode;
		logic       last;
		logic       empty;
		logic       is_lbracket;
		logic       is_rbracket;
		logic       is_colon;
		logic       is_dot;
		logic       is_dash;
		logic       is_digit;
		logic       is_hex_letter;
		logic       is_lower;
		logic       is_upper;
	} hpnv_item_t;

endpackage

// ===== rtl/hpnv_fifo.sv =====
// Small first-in first-out queue of WIDTH-bit entries.
// Used between front and back and for the verdicts; no package needed.
module hpnv_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_ok;
	logic             rd_ok;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_ok   = wr_en & ~full;
	assign rd_ok   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_ok, rd_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/hpnv_front.sv =====
// Front end: holds the mode register, accepts bytes and classifies them.
// Depends on hpnv_pkg for character codes and the item record.
module hpnv_front
	import hpnv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       push,
	input  logic       queue_full,
	input  logic [7:0] char_byte,
	input  logic       last_char,
	input  logic       empty_string,
	output logic       item_wr,
	output hpnv_item_t item
);

	logic [1:0] parse_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode_q <= MODE_HOST_PORT;
		end else if (cfg_valid) begin
			parse_mode_q <= cfg_data;
		end
	end

	assign item_wr = push & ~queue_full;

	always_comb begin
		item.mode          = parse_mode_q;
		item.last          = last_char;
		item.empty         = empty_string;
		item.is_lbracket   = (char_byte == CH_LBRACKET);
		item.is_rbracket   = (char_byte == CH_RBRACKET);
		item.is_colon      = (char_byte == CH_COLON);
		item.is_dot        = (char_byte == CH_DOT);
		item.is_dash       = (char_byte == CH_DASH);
		item.is_digit      = (char_byte >= 8'h30) && (char_byte <= 8'h39);
		item.is_hex_letter = ((char_byte >= 8'h61) && (char_byte <= 8'h66)) ||
		                     ((char_byte >= 8'h41) && (char_byte <= 8'h46));
		item.is_lower      = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
		item.is_upper      = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
	end

endmodule

// ===== rtl/hpnv_back.sv =====
// Back end: running syntax state per string and the verdict on the last byte.
// Depends on hpnv_pkg for modes, limits and the item record.
module hpnv_back
	import hpnv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_avail,
	input  hpnv_item_t item,
	output logic       item_take,
	input  logic       res_full,
	output logic       res_wr,
	output logic       res_bit
);

	localparam logic [1:0] PH_START   = 2'd0;
	localparam logic [1:0] PH_BODY    = 2'd1;
	localparam logic [1:0] PH_BRACKET = 2'd2;
	localparam logic [1:0] PH_AFTER   = 2'd3;

	logic [1:0] phase_q, n_phase;
	logic [1:0] colons_q, n_colons;
	logic [8:0] name_len_q, n_name_len;
	logic [6:0] label_len_q, n_label_len;
	logic       label_dash_q, n_label_dash;
	logic       name_err_q, n_name_err;
	logic [5:0] lit_len_q, n_lit_len;
	logic [2:0] group_len_q, n_group_len;
	logic       lit_err_q, n_lit_err;
	logic [2:0] port_len_q, n_port_len;
	logic       port_err_q, n_port_err;
	logic       port_colon_q, n_port_colon;

	logic do_domain, do_literal, do_port, do_colon, lower_only;
	logic alnum, is_hex, domain_ok, literal_ok, port_ok, verdict, ends;

	assign ends      = item.last | item.empty;
	assign item_take = item_avail & (~ends | ~res_full);
	assign res_wr    = item_take & ends;
	assign res_bit   = ~item.empty & verdict;

	// decide which sub-checks see this byte; port state is updated here too
	always_comb begin
		do_domain    = 1'b0;
		do_literal   = 1'b0;
		do_port      = 1'b0;
		do_colon     = 1'b0;
		lower_only   = 1'b0;
		n_phase      = phase_q;
		n_port_colon = port_colon_q;
		n_port_err   = port_err_q;
		if (item.mode != MODE_HOST_PORT) begin
			do_domain  = 1'b1;
			lower_only = item.mode[1];
			n_phase    = PH_BODY;
		end else begin
			unique case (phase_q)
				PH_START, PH_BODY: begin
					if (phase_q == PH_START && item.is_lbracket) begin
						n_phase = PH_BRACKET;
					end else begin
						n_phase    = PH_BODY;
						do_literal = 1'b1;
						if (item.is_colon) begin
							do_colon = 1'b1;
						end else if (colons_q == 2'd0) begin
							do_domain = 1'b1;
						end else if (colons_q == 2'd1) begin
							do_port = 1'b1;
						end
					end
				end
				PH_BRACKET: begin
					if (item.is_rbracket) begin
						n_phase = PH_AFTER;
					end else begin
						do_colon   = item.is_colon;
						do_domain  = 1'b1;
						do_literal = 1'b1;
					end
				end
				default: begin
					if (!port_colon_q) begin
						if (item.is_colon) begin
							n_port_colon = 1'b1;
						end else begin
							n_port_err = 1'b1;
						end
					end else begin
						do_port = 1'b1;
					end
				end
			endcase
		end

		n_port_len = port_len_q;
		if (do_port) begin
			if (item.is_digit) begin
				if (port_len_q != '1) begin
					n_port_len = port_len_q + 1'b1;
				end
			end else begin
				n_port_err = 1'b1;
			end
		end
	end

	// sub-check state updates
	always_comb begin
		alnum  = item.is_digit | item.is_lower | (~lower_only & item.is_upper);
		is_hex = item.is_digit | item.is_hex_letter;

		n_colons = colons_q;
		if (do_colon && colons_q != '1) begin
			n_colons = colons_q + 1'b1;
		end

		n_name_len   = name_len_q;
		n_label_len  = label_len_q;
		n_label_dash = label_dash_q;
		n_name_err   = name_err_q;
		if (do_domain) begin
			if (name_len_q != '1) begin
				n_name_len = name_len_q + 1'b1;
			end
			if (item.is_dot) begin
				if (label_len_q == '0 || label_len_q > 7'(MAX_LABEL) || label_dash_q) begin
					n_name_err = 1'b1;
				end
				n_label_len  = '0;
				n_label_dash = 1'b0;
			end else begin
				if (item.is_dash) begin
					if (label_len_q == '0) begin
						n_name_err = 1'b1;
					end
					n_label_dash = 1'b1;
				end else if (alnum) begin
					n_label_dash = 1'b0;
				end else begin
					n_name_err = 1'b1;
				end
				if (label_len_q != '1) begin
					n_label_len = label_len_q + 1'b1;
				end
			end
		end

		n_lit_len   = lit_len_q;
		n_group_len = group_len_q;
		n_lit_err   = lit_err_q;
		if (do_literal) begin
			if (lit_len_q != '1) begin
				n_lit_len = lit_len_q + 1'b1;
			end
			if (item.is_colon) begin
				n_group_len = '0;
			end else if (is_hex) begin
				if (group_len_q != '1) begin
					n_group_len = group_len_q + 1'b1;
				end
				if (n_group_len > 3'(MAX_GROUP_DIGITS)) begin
					n_lit_err = 1'b1;
				end
			end else begin
				n_lit_err = 1'b1;
			end
		end
	end

	// verdict on the updated state
	always_comb begin
		domain_ok  = ~n_name_err && n_label_len != '0 && n_label_len <= 7'(MAX_LABEL) &&
		             ~n_label_dash && n_name_len <= 9'(MAX_NAME);
		literal_ok = ~n_lit_err && n_lit_len != '0 && n_lit_len <= 6'(MAX_LITERAL);
		port_ok    = ~n_port_err && n_port_len != '0 && n_port_len <= 3'(MAX_PORT_DIGITS);
		verdict    = 1'b0;
		if (item.mode != MODE_HOST_PORT) begin
			verdict = domain_ok;
		end else if (n_phase == PH_BODY) begin
			if (n_colons[1]) begin
				verdict = literal_ok;
			end else if (n_colons[0]) begin
				verdict = domain_ok & port_ok;
			end else begin
				verdict = domain_ok;
			end
		end else if (n_phase == PH_AFTER) begin
			if (n_port_err || (n_port_colon && !port_ok)) begin
				verdict = 1'b0;
			end else begin
				verdict = (n_colons != '0) ? literal_ok : domain_ok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			colons_q     <= '0;
			name_len_q   <= '0;
			label_len_q  <= '0;
			label_dash_q <= 1'b0;
			name_err_q   <= 1'b0;
			lit_len_q    <= '0;
			group_len_q  <= '0;
			lit_err_q    <= 1'b0;
			port_len_q   <= '0;
			port_err_q   <= 1'b0;
			port_colon_q <= 1'b0;
		end else if (item_take) begin
			if (ends) begin
				phase_q      <= PH_START;
				colons_q     <= '0;
				name_len_q   <= '0;
				label_len_q  <= '0;
				label_dash_q <= 1'b0;
				name_err_q   <= 1'b0;
				lit_len_q    <= '0;
				group_len_q  <= '0;
				lit_err_q    <= 1'b0;
				port_len_q   <= '0;
				port_err_q   <= 1'b0;
				port_colon_q <= 1'b0;
			end else begin
				phase_q      <= n_phase;
				colons_q     <= n_colons;
				name_len_q   <= n_name_len;
				label_len_q  <= n_label_len;
				label_dash_q <= n_label_dash;
				name_err_q   <= n_name_err;
				lit_len_q    <= n_lit_len;
				group_len_q  <= n_group_len;
				lit_err_q    <= n_lit_err;
				port_len_q   <= n_port_len;
				port_err_q   <= n_port_err;
				port_colon_q <= n_port_colon;
			end
		end
	end

endmodule

// ===== rtl/host_port_name_validator_unit.sv =====
// Top level of the host/port and domain-name syntax checker.
// Depends on hpnv_pkg, hpnv_front, hpnv_fifo and hpnv_back.
//
// Usage:
//   Bytes of a string enter as requests on the push/full side, one per
//   cycle while full is low, with last_char on the final byte. An item with
//   empty_string set stands for a whole empty string and always yields 0.
//   Verdicts leave on the empty/pop side: valid_res is 1 when the string
//   passes the check selected by the mode register.
//   The mode register is written via cfg_valid/cfg_data, cfg_ready always
//   high; write it only between strings, which the block does not check.
// Timing:
//   One byte per cycle sustained while full is low. A verdict is visible
//   (empty low) once its classified last byte has left the front/back queue
//   and the back end has taken it; the back end updates its running state
//   and writes the verdict queue in the same cycle.
// Reset: clears the mode to host-with-port, empties both queues and
//   returns the parse state to the start of a string.
// Stall: when pop stays low the verdict queue fills, the back end holds
//   bytes that end a string, the byte queue fills and full goes high.
module host_port_name_validator_unit
	import hpnv_pkg::*;
#(
	parameter int QUEUE_DEPTH  = HPNV_QUEUE_DEPTH,
	parameter int RESULT_DEPTH = HPNV_RESULT_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_byte,
	input  logic       last_char,
	input  logic       empty_string,
	output logic       empty,
	input  logic       pop,
	output logic       valid_res
);

	hpnv_item_t front_item;
	hpnv_item_t back_item;
	logic       item_wr;
	logic       item_take;
	logic       queue_empty;
	logic       res_wr;
	logic       res_bit;
	logic       res_full;

	hpnv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.queue_full   (full),
		.char_byte    (char_byte),
		.last_char    (last_char),
		.empty_string (empty_string),
		.item_wr      (item_wr),
		.item         (front_item)
	);

	hpnv_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(hpnv_item_t))
	) u_item_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (item_wr),
		.wr_data (front_item),
		.full    (full),
		.rd_en   (item_take),
		.rd_data (back_item),
		.empty   (queue_empty)
	);

	hpnv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_avail (~queue_empty),
		.item       (back_item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_wr     (res_wr),
		.res_bit    (res_bit)
	);

	hpnv_fifo #(
		.DEPTH (RESULT_DEPTH),
		.WIDTH (1)
	) u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_data (res_bit),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (valid_res),
		.empty   (empty)
	);

endmodule
